[hdl/cmma_pkg.sv]
package cmma_pkg;

  // Ring depth; the block works for any depth from 1 to 64.
  localparam int WINDOW = 25;

  localparam int DATA_W = 16;
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = DATA_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W + 1);

  localparam int ADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [DATA_W-1:0] CLAMP_RESET = DATA_W'(10000);
  localparam logic [DATA_W-1:0] MIN_RESET   = DATA_W'(50000);

  // Register index of the clamp limit.
  localparam logic REG_CLAMP_LIMIT = 1'b0;

endpackage

[hdl/cmma_ring_ram.sv]
module cmma_ring_ram (
  input  logic                             clk,
  input  logic                             we,
  input  logic [cmma_pkg::POS_W-1:0]       waddr,
  input  logic [cmma_pkg::DATA_W-1:0]      wdata,
  input  logic                             re,
  input  logic [cmma_pkg::POS_W-1:0]       raddr,
  output logic [cmma_pkg::DATA_W-1:0]      rdata
);

  logic [cmma_pkg::DATA_W-1:0] mem [cmma_pkg::WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/cmma_divider.sv]
module cmma_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cmma_pkg::SUM_W-1:0]    dividend,
  input  logic [cmma_pkg::CNT_W-1:0]    divisor,
  output logic                          done,
  output logic [cmma_pkg::DATA_W-1:0]   quotient
);

  logic                          busy_r;
  logic                          done_r;
  logic [cmma_pkg::STEP_W-1:0]   step_r;
  logic [cmma_pkg::CNT_W-1:0]    rem_r;
  logic [cmma_pkg::SUM_W-1:0]    quo_r;
  logic [cmma_pkg::CNT_W-1:0]    div_r;

  logic [cmma_pkg::CNT_W:0]      trial;
  logic                          fits;
  logic [cmma_pkg::CNT_W-1:0]    rem_nxt;

  // One restoring step per cycle; the dividend shifts out of quo_r as the
  // quotient bits shift in.
  always_comb begin
    trial   = {rem_r, quo_r[cmma_pkg::SUM_W-1]};
    fits    = (trial >= {1'b0, div_r});
    rem_nxt = fits ? cmma_pkg::CNT_W'(trial - {1'b0, div_r})
                   : trial[cmma_pkg::CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= cmma_pkg::STEP_W'(cmma_pkg::SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == cmma_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[cmma_pkg::SUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[cmma_pkg::DATA_W-1:0];

endmodule

[hdl/clamped_min_max_moving_average_top.sv]
// Each accepted item passes through the update state and then the bit-serial divider,
// which divides the window sum by the fill count one quotient bit a cycle; no new item
// is taken until the result of the last one has been loaded into the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n low, synchronous) clears the control state, fill count, sum and
// position, sets the clamp limit to 10000, the minimum to 50000 and the maximum to 0.
module clamped_min_max_moving_average_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cmma_pkg::DATA_W-1:0]       in_raw_distance,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cmma_pkg::DATA_W-1:0]       out_current_value,
  output logic [cmma_pkg::DATA_W-1:0]       out_minimum_value,
  output logic [cmma_pkg::DATA_W-1:0]       out_maximum_value,
  output logic [cmma_pkg::DATA_W-1:0]       out_window_average,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cmma_pkg::ADDR_W-1:0]       paddr,
  input  logic [cmma_pkg::PDATA_W-1:0]      pwdata,
  output logic [cmma_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_DIV  = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [cmma_pkg::DATA_W-1:0]     clamp_r;
  logic [cmma_pkg::DATA_W-1:0]     sample_r;
  logic [cmma_pkg::POS_W-1:0]      pos_r;
  logic [cmma_pkg::CNT_W-1:0]      fill_r;
  logic [cmma_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [cmma_pkg::DATA_W-1:0]     min_r, max_r;
  logic                            out_valid_r;
  logic [cmma_pkg::DATA_W-1:0]     out_cur_r, out_min_r, out_max_r, out_avg_r;

  logic                            in_accept;
  logic                            cfg_write;
  logic                            full;
  logic [cmma_pkg::DATA_W-1:0]     clamped;
  logic [cmma_pkg::DATA_W-1:0]     old_sample;
  logic                            div_start;
  logic                            div_done;
  logic [cmma_pkg::DATA_W-1:0]     quotient;
  logic                            out_free;
  logic                            load_out;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == cmma_pkg::REG_CLAMP_LIMIT);
  assign prdata    = (paddr[2] == cmma_pkg::REG_CLAMP_LIMIT)
                     ? {{(cmma_pkg::PDATA_W-cmma_pkg::DATA_W){1'b0}}, clamp_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_r <= cmma_pkg::CLAMP_RESET;
    end else if (cfg_write) begin
      clamp_r <= pwdata[cmma_pkg::DATA_W-1:0];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign clamped   = (in_raw_distance > clamp_r) ? clamp_r : in_raw_distance;
  assign full      = (fill_r == cmma_pkg::CNT_W'(cmma_pkg::WINDOW));

  // The old entry is only subtracted once the ring has been filled.
  assign sum_nxt = sum_r - (full ? cmma_pkg::SUM_W'(old_sample) : '0)
                   + cmma_pkg::SUM_W'(sample_r);

  assign div_start = (state_r == S_UPD);
  assign out_free  = !out_valid_r || !out_stall;
  assign load_out  = ((state_r == S_DIV) && div_done || (state_r == S_HOLD)) && out_free;

  cmma_ring_ram u_ram (
    .clk   (clk),
    .we    (state_r == S_UPD),
    .waddr (pos_r),
    .wdata (sample_r),
    .re    (in_accept),
    .raddr (pos_r),
    .rdata (old_sample)
  );

  cmma_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (full ? fill_r : fill_r + 1'b1),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      min_r       <= cmma_pkg::MIN_RESET;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_UPD) begin
        sum_r <= sum_nxt;
        if (!full) fill_r <= fill_r + 1'b1;
        pos_r <= (pos_r == cmma_pkg::POS_W'(cmma_pkg::WINDOW - 1)) ? '0 : pos_r + 1'b1;
        if (sample_r < min_r) min_r <= sample_r;
        if (sample_r > max_r) max_r <= sample_r;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= clamped;
    end
    if (load_out) begin
      out_cur_r <= sample_r;
      out_min_r <= min_r;
      out_max_r <= max_r;
      out_avg_r <= quotient;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_current_value  = out_cur_r;
  assign out_minimum_value  = out_min_r;
  assign out_maximum_value  = out_max_r;
  assign out_window_average = out_avg_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cmma_pkg::CNT_W'(cmma_pkg::WINDOW))
    else $error("fill count exceeds ring depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= cmma_pkg::POS_W'(cmma_pkg::WINDOW - 1))
    else $error("write position outside ring");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide phase");

  a_fill_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |=> fill_r != '0)
    else $error("fill count zero after an update");
`endif

endmodule
